/* sv/hrp_pkg.sv */
// Package with the shared types, codes, character constants and match tables of the parser.
`default_nettype none

package hrp_pkg;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_MALFORMED = 2'd1;
    localparam logic [1:0] STATUS_TOO_LONG  = 2'd2;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_LOW_C = 8'h63;

    localparam logic [23:0] CR_LF_CR = 24'h0D0A0D;

    localparam logic [4:0] CL_LEN    = 5'd15;
    localparam logic [4:0] CONN_LEN  = 5'd11;
    localparam logic [2:0] CLOSE_LEN = 3'd5;

    localparam logic [2:0] MS_GET_LAST  = 3'd3;
    localparam logic [2:0] MS_POST_FIRST = 3'd4;
    localparam logic [2:0] MS_POST_LAST = 3'd7;

    typedef enum logic [1:0] {
        MC_MATCH,
        MC_GET,
        MC_POST,
        MC_FAIL
    } t_mcode;

    typedef enum logic [1:0] {
        PP_BEFORE,
        PP_PATH,
        PP_QUERY,
        PP_DONE
    } t_pphase;

    typedef enum logic [2:0] {
        LN_NONE,
        LN_BOTH,
        LN_CL,
        LN_CONN,
        LN_SPACE,
        LN_DIGITS,
        LN_SEARCH,
        LN_SKIP
    } t_lphase;

    typedef struct packed {
        logic       kind;
        logic [7:0] path_char;
        logic [1:0] status;
        logic       method;
        logic [10:0] head_len;
        logic [6:0] path_len;
        logic [31:0] body_len;
        logic       conn_close;
    } t_out_word;

    typedef struct packed {
        logic       valid;
        t_out_word  word;
    } t_result;

    typedef struct packed {
        logic       step;
        logic       clear;
        logic       active;
        logic [7:0] data;
    } t_line_ctl;

    typedef struct packed {
        logic [31:0] length;
        logic        close;
    } t_line_sts;

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
    endfunction

    // Expected byte at each method stage after the first letter.
    function automatic logic [7:0] method_char(input logic [2:0] stage);
        logic [7:0] c;
        case (stage)
            3'd1:    c = 8'h45;
            3'd2:    c = 8'h54;
            3'd3:    c = CH_SPACE;
            3'd4:    c = 8'h4F;
            3'd5:    c = 8'h53;
            3'd6:    c = 8'h54;
            3'd7:    c = CH_SPACE;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] cl_char(input logic [4:0] pos);
        logic [7:0] c;
        case (pos)
            5'd0:    c = 8'h63;
            5'd1:    c = 8'h6F;
            5'd2:    c = 8'h6E;
            5'd3:    c = 8'h74;
            5'd4:    c = 8'h65;
            5'd5:    c = 8'h6E;
            5'd6:    c = 8'h74;
            5'd7:    c = 8'h2D;
            5'd8:    c = 8'h6C;
            5'd9:    c = 8'h65;
            5'd10:   c = 8'h6E;
            5'd11:   c = 8'h67;
            5'd12:   c = 8'h74;
            5'd13:   c = 8'h68;
            5'd14:   c = 8'h3A;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] conn_char(input logic [4:0] pos);
        logic [7:0] c;
        case (pos)
            5'd0:    c = 8'h63;
            5'd1:    c = 8'h6F;
            5'd2:    c = 8'h6E;
            5'd3:    c = 8'h6E;
            5'd4:    c = 8'h65;
            5'd5:    c = 8'h63;
            5'd6:    c = 8'h74;
            5'd7:    c = 8'h69;
            5'd8:    c = 8'h6F;
            5'd9:    c = 8'h6E;
            5'd10:   c = 8'h3A;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] close_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h63;
            3'd1:    c = 8'h6C;
            3'd2:    c = 8'h6F;
            3'd3:    c = 8'h73;
            3'd4:    c = 8'h65;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* sv/hrp_ifs.sv */
// Valid/ready channel interfaces for the request byte words and the result words.
`default_nettype none

interface hrp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] head_byte;
    logic       start_flag;

    modport source (output valid, output head_byte, output start_flag, input ready);
    modport sink (input valid, input head_byte, input start_flag, output ready);
endinterface

interface hrp_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  path_char;
    logic [1:0]  status;
    logic        method;
    logic [10:0] head_len;
    logic [6:0]  path_len;
    logic [31:0] body_len;
    logic        conn_close;

    modport source (
        output valid, output kind, output path_char, output status, output method,
        output head_len, output path_len, output body_len,
        output conn_close, input ready
    );
    modport sink (
        input valid, input kind, input path_char, input status, input method,
        input head_len, input path_len, input body_len,
        input conn_close, output ready
    );
endinterface

`default_nettype wire

/* sv/hrp_line.sv */
// Header line matcher for Content-Length and Connection: close.
`default_nettype none

module hrp_line (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hrp_pkg::t_line_ctl i_ctl,
    output hrp_pkg::t_line_sts o_sts
);

    hrp_pkg::t_lphase r_phase, n_phase, cur_phase;
    logic [4:0]  r_pos, n_pos, cur_pos;
    logic [31:0] r_len, n_len, cur_len;
    logic        r_close, n_close, cur_close;
    logic [2:0]  r_cpos, n_cpos, cur_cpos;

    always_comb begin
        logic [7:0] c;
        logic       a_hit;
        logic       n_hit;
        logic       is_digit;
        logic [7:0] digit;

        cur_phase = i_ctl.clear ? hrp_pkg::LN_NONE : r_phase;
        cur_pos   = i_ctl.clear ? 5'd0 : r_pos;
        cur_len   = i_ctl.clear ? 32'd0 : r_len;
        cur_close = i_ctl.clear ? 1'b0 : r_close;
        cur_cpos  = i_ctl.clear ? 3'd0 : r_cpos;

        c        = hrp_pkg::to_lower(i_ctl.data);
        is_digit = (i_ctl.data >= hrp_pkg::CH_ZERO) && (i_ctl.data <= hrp_pkg::CH_NINE);
        digit    = i_ctl.data - hrp_pkg::CH_ZERO;
        a_hit    = 1'b0;
        n_hit    = 1'b0;

        n_phase = cur_phase;
        n_pos   = cur_pos;
        n_len   = cur_len;
        n_close = cur_close;
        n_cpos  = cur_cpos;

        if (i_ctl.active) begin
            if (i_ctl.data == hrp_pkg::CH_LF) begin
                n_phase = hrp_pkg::LN_BOTH;
                n_pos   = 5'd0;
            end else begin
                unique case (cur_phase) inside
                    hrp_pkg::LN_BOTH, hrp_pkg::LN_CL, hrp_pkg::LN_CONN: begin
                        a_hit = (cur_phase != hrp_pkg::LN_CONN) && (cur_pos < hrp_pkg::CL_LEN)
                                && (c == hrp_pkg::cl_char(cur_pos));
                        n_hit = (cur_phase != hrp_pkg::LN_CL) && (cur_pos < hrp_pkg::CONN_LEN)
                                && (c == hrp_pkg::conn_char(cur_pos));
                        if (a_hit || n_hit) begin
                            if (a_hit && n_hit) begin
                                n_phase = hrp_pkg::LN_BOTH;
                            end else if (a_hit) begin
                                n_phase = hrp_pkg::LN_CL;
                            end else begin
                                n_phase = hrp_pkg::LN_CONN;
                            end
                            n_pos = cur_pos + 5'd1;
                            if (n_phase == hrp_pkg::LN_CL && n_pos == hrp_pkg::CL_LEN) begin
                                n_len   = 32'd0;
                                n_phase = hrp_pkg::LN_SPACE;
                            end else if (n_phase == hrp_pkg::LN_CONN
                                         && n_pos == hrp_pkg::CONN_LEN) begin
                                n_cpos  = 3'd0;
                                n_phase = hrp_pkg::LN_SEARCH;
                            end
                        end else begin
                            n_phase = hrp_pkg::LN_SKIP;
                        end
                    end
                    hrp_pkg::LN_SPACE: begin
                        if (i_ctl.data != hrp_pkg::CH_SPACE && i_ctl.data != hrp_pkg::CH_TAB) begin
                            if (is_digit) begin
                                n_len   = 32'(digit);
                                n_phase = hrp_pkg::LN_DIGITS;
                            end else begin
                                n_phase = hrp_pkg::LN_SKIP;
                            end
                        end
                    end
                    hrp_pkg::LN_DIGITS: begin
                        if (is_digit) begin
                            n_len = (cur_len << 3) + (cur_len << 1) + 32'(digit);
                        end else begin
                            n_phase = hrp_pkg::LN_SKIP;
                        end
                    end
                    hrp_pkg::LN_SEARCH: begin
                        if (cur_cpos < hrp_pkg::CLOSE_LEN && c == hrp_pkg::close_char(cur_cpos)) begin
                            n_cpos = cur_cpos + 3'd1;
                            if (n_cpos == hrp_pkg::CLOSE_LEN) begin
                                n_close = 1'b1;
                                n_phase = hrp_pkg::LN_SKIP;
                            end
                        end else begin
                            n_cpos = (c == hrp_pkg::CH_LOW_C) ? 3'd1 : 3'd0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_sts.length = n_len;
    assign o_sts.close  = n_close;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= hrp_pkg::LN_NONE;
            r_pos   <= 5'd0;
            r_len   <= 32'd0;
            r_close <= 1'b0;
            r_cpos  <= 3'd0;
        end else if (i_ctl.step) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_len   <= n_len;
            r_close <= n_close;
            r_cpos  <= n_cpos;
        end
    end

endmodule

`default_nettype wire

/* sv/hrp_req.sv */
// Request line tracker: method, path, byte count, terminator and result selection.
`default_nettype none

module hrp_req #(
    parameter int MAX_HEAD = 1024,
    parameter int MAX_PATH = 128
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_byte,
    input  logic            i_start,
    output hrp_pkg::t_result o_res
);

    localparam int CntW = $clog2(MAX_HEAD + 1);
    localparam int PcW  = $clog2(MAX_PATH + 1);

    logic             r_done, n_done, cur_done;
    logic [CntW-1:0]  r_count, n_count, cur_count;
    logic [23:0]      r_recent, n_recent, cur_recent;
    logic [2:0]       r_stage, n_stage, cur_stage;
    hrp_pkg::t_mcode  r_code, n_code, cur_code;
    hrp_pkg::t_pphase r_pphase, n_pphase, cur_pphase;
    logic [PcW-1:0]   r_pcount, n_pcount, cur_pcount;

    logic               step;
    logic               path_out;
    logic               term;
    logic               overrun;
    hrp_pkg::t_line_ctl line_ctl;
    hrp_pkg::t_line_sts line_sts;

    always_comb begin
        cur_done   = i_start ? 1'b0 : r_done;
        cur_count  = i_start ? '0 : r_count;
        cur_recent = i_start ? 24'd0 : r_recent;
        cur_stage  = i_start ? 3'd0 : r_stage;
        cur_code   = i_start ? hrp_pkg::MC_MATCH : r_code;
        cur_pphase = i_start ? hrp_pkg::PP_BEFORE : r_pphase;
        cur_pcount = i_start ? '0 : r_pcount;

        step     = i_valid && !cur_done;
        path_out = 1'b0;
        n_stage  = cur_stage;
        n_code   = cur_code;
        n_pphase = cur_pphase;
        n_pcount = cur_pcount;

        if (cur_code == hrp_pkg::MC_MATCH) begin
            if (cur_stage == 3'd0) begin
                if (i_byte == hrp_pkg::CH_G) begin
                    n_stage = 3'd1;
                end else if (i_byte == hrp_pkg::CH_P) begin
                    n_stage = hrp_pkg::MS_POST_FIRST;
                end else begin
                    n_code = hrp_pkg::MC_FAIL;
                end
            end else if (i_byte != hrp_pkg::method_char(cur_stage)) begin
                n_code = hrp_pkg::MC_FAIL;
            end else if (cur_stage == hrp_pkg::MS_GET_LAST) begin
                n_code   = hrp_pkg::MC_GET;
                n_pphase = hrp_pkg::PP_PATH;
            end else if (cur_stage == hrp_pkg::MS_POST_LAST) begin
                n_code   = hrp_pkg::MC_POST;
                n_pphase = hrp_pkg::PP_PATH;
            end else begin
                n_stage = cur_stage + 3'd1;
            end
        end else if (cur_code != hrp_pkg::MC_FAIL) begin
            if (cur_pphase == hrp_pkg::PP_PATH) begin
                if (i_byte == hrp_pkg::CH_SPACE) begin
                    n_pphase = hrp_pkg::PP_DONE;
                end else if (i_byte == hrp_pkg::CH_QMARK) begin
                    n_pphase = hrp_pkg::PP_QUERY;
                end else begin
                    if (cur_pcount < PcW'(MAX_PATH - 1)) begin
                        path_out = 1'b1;
                    end
                    if (cur_pcount < PcW'(MAX_PATH)) begin
                        n_pcount = cur_pcount + PcW'(1);
                    end
                end
            end else if (cur_pphase == hrp_pkg::PP_QUERY && i_byte == hrp_pkg::CH_SPACE) begin
                n_pphase = hrp_pkg::PP_DONE;
            end
        end

        term     = (i_byte == hrp_pkg::CH_LF) && (cur_recent == hrp_pkg::CR_LF_CR);
        n_recent = {cur_recent[15:0], i_byte};
        n_count  = cur_count + CntW'(1);
        overrun  = (n_count == CntW'(MAX_HEAD));
        n_done   = term || overrun;

        line_ctl.step   = step;
        line_ctl.clear  = i_start;
        line_ctl.active = (cur_code == hrp_pkg::MC_GET) || (cur_code == hrp_pkg::MC_POST);
        line_ctl.data   = i_byte;

        o_res.valid = step && (term || overrun || path_out);
        o_res.word  = '0;
        if (term) begin
            o_res.word.kind     = 1'b1;
            o_res.word.head_len = 11'(n_count);
            if (n_code != hrp_pkg::MC_GET && n_code != hrp_pkg::MC_POST) begin
                o_res.word.status = hrp_pkg::STATUS_MALFORMED;
            end else if (n_pphase != hrp_pkg::PP_DONE) begin
                o_res.word.status = hrp_pkg::STATUS_MALFORMED;
            end else if (n_pcount == '0) begin
                o_res.word.status = hrp_pkg::STATUS_MALFORMED;
            end else if (n_pcount >= PcW'(MAX_PATH)) begin
                o_res.word.status = hrp_pkg::STATUS_TOO_LONG;
            end else begin
                o_res.word.status     = hrp_pkg::STATUS_OK;
                o_res.word.method     = (n_code == hrp_pkg::MC_POST);
                o_res.word.path_len   = 7'(n_pcount);
                o_res.word.body_len   = line_sts.length;
                o_res.word.conn_close = line_sts.close;
            end
        end else if (overrun) begin
            o_res.word.kind     = 1'b1;
            o_res.word.status   = hrp_pkg::STATUS_TOO_LONG;
            o_res.word.head_len = 11'(n_count);
        end else if (path_out) begin
            o_res.word.path_char = i_byte;
        end
    end

    hrp_line u_line (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (line_ctl),
        .o_sts   (line_sts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done   <= 1'b0;
            r_count  <= '0;
            r_recent <= 24'd0;
            r_stage  <= 3'd0;
            r_code   <= hrp_pkg::MC_MATCH;
            r_pphase <= hrp_pkg::PP_BEFORE;
            r_pcount <= '0;
        end else if (step) begin
            r_done   <= n_done;
            r_count  <= n_count;
            r_recent <= n_recent;
            r_stage  <= n_stage;
            r_code   <= n_code;
            r_pphase <= n_pphase;
            r_pcount <= n_pcount;
        end
    end

endmodule

`default_nettype wire

/* sv/http_request_head_parser_core.sv */
// Top level of the streaming request head parser with input and result registers.
//
// Usage: request head bytes enter one word at a time on i_req; start_flag set on a
// word marks the first byte of a new request and clears all parser state before
// that byte is taken. Results leave on o_res: a kind 0 word carries one path byte,
// a kind 1 word carries the summary (status, method, head size, path length,
// content length and close flag) and ends the request; later bytes give no result
// until the next start_flag.
// Order: an accepted byte is held in the input register, and its result, if any, in
// the result register that drives o_res. Throughput is one byte per cycle while o_res
// is not stalled, set by the single registered pass that updates the method, path and
// header line matchers; while a result waits on o_res the block takes one more byte.
// Stall: when o_res is held not ready, one result word and one input word stay
// registered and i_req.ready drops; nothing is lost or repeated.
// Reset: i_rst_n low clears the valid flags of both registers and all parser state;
// no result is produced from an incomplete head.
`default_nettype none

module http_request_head_parser_core #(
    parameter int MAX_HEAD = 1024,
    parameter int MAX_PATH = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hrp_in_if.sink     i_req,
    hrp_out_if.source  o_res
);

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_in_start;
    logic               r_out_valid;
    hrp_pkg::t_out_word r_out_word;
    logic               advance;
    hrp_pkg::t_result   res;

    assign advance     = !r_out_valid || o_res.ready;
    assign i_req.ready = !r_in_valid || advance;

    hrp_req #(
        .MAX_HEAD (MAX_HEAD),
        .MAX_PATH (MAX_PATH)
    ) u_req (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid && advance),
        .i_byte  (r_in_byte),
        .i_start (r_in_start),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_byte  <= i_req.head_byte;
            r_in_start <= i_req.start_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid && res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid && res.valid) begin
            r_out_word <= res.word;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.kind       = r_out_word.kind;
    assign o_res.path_char  = r_out_word.path_char;
    assign o_res.status     = r_out_word.status;
    assign o_res.method     = r_out_word.method;
    assign o_res.head_len   = r_out_word.head_len;
    assign o_res.path_len   = r_out_word.path_len;
    assign o_res.body_len   = r_out_word.body_len;
    assign o_res.conn_close = r_out_word.conn_close;

endmodule

`default_nettype wire

/* tb/tb.sv */
// Testbench for the request head parser core: directed and random heads checked against a predictor.
`default_nettype none

class hrp_scoreboard #(int HEAD_LIMIT = 1024, int PATH_LIMIT = 128);

    string get_text   = "GET ";
    string post_text  = "POST ";
    string cl_text    = "content-length:";
    string conn_text  = "connection:";
    string close_text = "close";

    int unsigned      n_bytes;
    logic [23:0]      tail3;
    logic [2:0]       meth_stage;
    hrp_pkg::t_mcode  meth;
    hrp_pkg::t_pphase pphase;
    int unsigned      path_n;
    int unsigned      name_pos;
    hrp_pkg::t_lphase lphase;
    logic [31:0]      clen;
    bit               close_seen;
    int unsigned      close_pos;
    bit               finished;

    hrp_pkg::t_out_word expected_words[$];
    int unsigned        mismatches;

    function new();
        clear_request();
        mismatches = 0;
    endfunction

    function void clear_request();
        n_bytes = 0;
        tail3 = '0;
        meth_stage = '0;
        meth = hrp_pkg::MC_MATCH;
        pphase = hrp_pkg::PP_BEFORE;
        path_n = 0;
        name_pos = 0;
        lphase = hrp_pkg::LN_NONE;
        clen = '0;
        close_seen = 0;
        close_pos = 0;
        finished = 0;
    endfunction

    function logic [7:0] fold_case(logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) ? (b | 8'h20) : b;
    endfunction

    function void advance_method(logic [7:0] b);
        if (meth_stage == 3'd0) begin
            if (b == hrp_pkg::CH_G) meth_stage = 3'd1;
            else if (b == hrp_pkg::CH_P) meth_stage = hrp_pkg::MS_POST_FIRST;
            else meth = hrp_pkg::MC_FAIL;
        end else if (meth_stage <= hrp_pkg::MS_GET_LAST) begin
            if (b != get_text[meth_stage]) meth = hrp_pkg::MC_FAIL;
            else if (meth_stage == hrp_pkg::MS_GET_LAST) begin
                meth = hrp_pkg::MC_GET;
                pphase = hrp_pkg::PP_PATH;
            end else meth_stage = meth_stage + 3'd1;
        end else begin
            if (b != post_text[meth_stage - 3'd3]) meth = hrp_pkg::MC_FAIL;
            else if (meth_stage == hrp_pkg::MS_POST_LAST) begin
                meth = hrp_pkg::MC_POST;
                pphase = hrp_pkg::PP_PATH;
            end else meth_stage = meth_stage + 3'd1;
        end
    endfunction

    function void advance_line(logic [7:0] b);
        logic [7:0] c;
        bit a;
        bit n;
        c = fold_case(b);
        if (b == hrp_pkg::CH_LF) begin
            lphase = hrp_pkg::LN_BOTH;
            name_pos = 0;
            return;
        end
        case (lphase) inside
            hrp_pkg::LN_BOTH, hrp_pkg::LN_CL, hrp_pkg::LN_CONN: begin
                a = lphase != hrp_pkg::LN_CONN && name_pos < hrp_pkg::CL_LEN &&
                    c == cl_text[name_pos];
                n = lphase != hrp_pkg::LN_CL && name_pos < hrp_pkg::CONN_LEN &&
                    c == conn_text[name_pos];
                if (a && n) lphase = hrp_pkg::LN_BOTH;
                else if (a) lphase = hrp_pkg::LN_CL;
                else if (n) lphase = hrp_pkg::LN_CONN;
                else lphase = hrp_pkg::LN_SKIP;
                if (a || n) begin
                    name_pos++;
                    if (lphase == hrp_pkg::LN_CL && name_pos == hrp_pkg::CL_LEN) begin
                        clen = '0;
                        lphase = hrp_pkg::LN_SPACE;
                    end else if (lphase == hrp_pkg::LN_CONN && name_pos == hrp_pkg::CONN_LEN) begin
                        close_pos = 0;
                        lphase = hrp_pkg::LN_SEARCH;
                    end
                end
            end
            hrp_pkg::LN_SPACE: begin
                if (b != hrp_pkg::CH_SPACE && b != hrp_pkg::CH_TAB) begin
                    if (b >= hrp_pkg::CH_ZERO && b <= hrp_pkg::CH_NINE) begin
                        clen = 32'(b - hrp_pkg::CH_ZERO);
                        lphase = hrp_pkg::LN_DIGITS;
                    end else lphase = hrp_pkg::LN_SKIP;
                end
            end
            hrp_pkg::LN_DIGITS: begin
                if (b >= hrp_pkg::CH_ZERO && b <= hrp_pkg::CH_NINE)
                    clen = clen * 32'd10 + 32'(b - hrp_pkg::CH_ZERO);
                else lphase = hrp_pkg::LN_SKIP;
            end
            hrp_pkg::LN_SEARCH: begin
                if (close_pos < hrp_pkg::CLOSE_LEN && c == close_text[close_pos]) begin
                    close_pos++;
                    if (close_pos == hrp_pkg::CLOSE_LEN) begin
                        close_seen = 1;
                        lphase = hrp_pkg::LN_SKIP;
                    end
                end else close_pos = (c == hrp_pkg::CH_LOW_C) ? 1 : 0;
            end
            default: ;
        endcase
    endfunction

    function void note_word(logic [7:0] b, logic st);
        bit emit_path;
        bit term;
        logic [1:0] status;
        hrp_pkg::t_out_word w;
        emit_path = 0;
        if (st) clear_request();
        if (finished) return;
        if (meth == hrp_pkg::MC_MATCH) advance_method(b);
        else if (meth != hrp_pkg::MC_FAIL) begin
            if (pphase == hrp_pkg::PP_PATH) begin
                if (b == hrp_pkg::CH_SPACE) pphase = hrp_pkg::PP_DONE;
                else if (b == hrp_pkg::CH_QMARK) pphase = hrp_pkg::PP_QUERY;
                else begin
                    if (path_n < PATH_LIMIT - 1) emit_path = 1;
                    if (path_n < PATH_LIMIT) path_n++;
                end
            end else if (pphase == hrp_pkg::PP_QUERY && b == hrp_pkg::CH_SPACE)
                pphase = hrp_pkg::PP_DONE;
            advance_line(b);
        end
        term = (b == hrp_pkg::CH_LF) && (tail3 == hrp_pkg::CR_LF_CR);
        tail3 = {tail3[15:0], b};
        n_bytes++;
        w = '0;
        if (term) begin
            if (meth != hrp_pkg::MC_GET && meth != hrp_pkg::MC_POST)
                status = hrp_pkg::STATUS_MALFORMED;
            else if (pphase != hrp_pkg::PP_DONE) status = hrp_pkg::STATUS_MALFORMED;
            else if (path_n == 0) status = hrp_pkg::STATUS_MALFORMED;
            else if (path_n >= PATH_LIMIT) status = hrp_pkg::STATUS_TOO_LONG;
            else status = hrp_pkg::STATUS_OK;
            w.kind = 1'b1;
            w.status = status;
            w.head_len = 11'(n_bytes);
            if (status == hrp_pkg::STATUS_OK) begin
                w.method = (meth == hrp_pkg::MC_POST);
                w.path_len = 7'(path_n);
                w.body_len = clen;
                w.conn_close = close_seen;
            end
        end else if (n_bytes >= HEAD_LIMIT) begin
            w.kind = 1'b1;
            w.status = hrp_pkg::STATUS_TOO_LONG;
            w.head_len = 11'(n_bytes);
        end else if (emit_path) begin
            w.path_char = b;
        end
        if (term || n_bytes >= HEAD_LIMIT) begin
            finished = 1;
            expected_words.push_back(w);
        end else if (emit_path) expected_words.push_back(w);
    endfunction

    function string word_text(hrp_pkg::t_out_word w);
        return $sformatf({"kind=%0d char=%02h status=%0d method=%0d size=%0d ",
                          "plen=%0d blen=%0d close=%0d"},
                         w.kind, w.path_char, w.status, w.method, w.head_len,
                         w.path_len, w.body_len, w.conn_close);
    endfunction

    task report_mismatch(string msg);
        mismatches++;
        $display("MISMATCH: %s", msg);
    endtask

    task check_result(hrp_pkg::t_out_word got);
        hrp_pkg::t_out_word want;
        string diff;
        if (expected_words.size() == 0) begin
            report_mismatch({"result with nothing expected: ", word_text(got)});
            return;
        end
        want = expected_words.pop_front();
        diff = "";
        if (got.kind !== want.kind) diff = {diff, " kind"};
        if (got.path_char !== want.path_char) diff = {diff, " path_char"};
        if (got.status !== want.status) diff = {diff, " status"};
        if (got.method !== want.method) diff = {diff, " method"};
        if (got.head_len !== want.head_len) diff = {diff, " head_len"};
        if (got.path_len !== want.path_len) diff = {diff, " path_len"};
        if (got.body_len !== want.body_len) diff = {diff, " body_len"};
        if (got.conn_close !== want.conn_close) diff = {diff, " conn_close"};
        if (diff != "")
            report_mismatch({"fields", diff, " differ: got ", word_text(got),
                             " expected ", word_text(want)});
    endtask

endclass

module tb;

    localparam int HEAD_LIMIT   = 1024;
    localparam int PATH_LIMIT   = 128;
    localparam int QUIET_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 64;
    localparam int RANDOM_BYTES = 550;
    localparam logic [7:0] CH_CR = 8'h0D;

    logic i_clk;
    logic i_rst_n;

    hrp_in_if  req ();
    hrp_out_if res ();

    http_request_head_parser_core #(
        .MAX_HEAD(HEAD_LIMIT),
        .MAX_PATH(PATH_LIMIT)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_res   (res)
    );

    hrp_scoreboard #(HEAD_LIMIT, PATH_LIMIT) board;

    logic [7:0]         pending_text[$];
    bit                 idle_on;
    bit                 hold_req;
    int unsigned        sent_bytes;
    int unsigned        quiet_cycles;
    hrp_pkg::t_out_word seen_word;

    string conn_values[6] = '{"close", "keep-alive", "Keep-Alive, Close", "clos", "cclose",
                              "upgrade"};
    string other_headers[6] = '{"Host: h", "Content-Type: close", "Conn: close",
                                "content-lengt: 5", "Connectio: close", "Accept: */*"};

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic add_byte(input logic [7:0] b);
        pending_text.push_back(b);
    endtask

    task automatic add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) pending_text.push_back(s[i]);
    endtask

    task automatic add_mixed_case(input string s);
        int i;
        logic [7:0] c;
        for (i = 0; i < s.len(); i++) begin
            c = s[i];
            if (((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) &&
                $urandom_range(1) != 0)
                c = c ^ 8'h20;
            pending_text.push_back(c);
        end
    endtask

    task automatic add_line(input string s);
        add_text(s);
        pending_text.push_back(CH_CR);
        pending_text.push_back(hrp_pkg::CH_LF);
    endtask

    task automatic add_fill(input logic [7:0] c, input int n);
        int i;
        for (i = 0; i < n; i++) pending_text.push_back(c);
    endtask

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(7))
            0: return CH_CR;
            1: return hrp_pkg::CH_LF;
            2: return hrp_pkg::CH_SPACE;
            3: return hrp_pkg::CH_QMARK;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_word(input logic [7:0] b, input logic st);
        while (idle_on && $urandom_range(99) < 17) begin
            req.valid <= 1'b0;
            @(negedge i_clk);
        end
        req.valid <= 1'b1;
        req.head_byte <= b;
        req.start_flag <= st;
        do @(posedge i_clk); while (!req.ready);
        board.note_word(b, st);
        sent_bytes++;
        @(negedge i_clk);
    endtask

    task automatic send_request(input bit with_start);
        int i;
        for (i = 0; i < pending_text.size(); i++)
            send_word(pending_text[i], with_start && i == 0);
        pending_text.delete();
    endtask

    task automatic add_header();
        int unsigned i;
        int unsigned n;
        case ($urandom_range(3))
            0: begin
                add_mixed_case("Content-Length:");
                n = $urandom_range(0, 2);
                for (i = 0; i < n; i++)
                    add_byte(($urandom_range(1) != 0) ? hrp_pkg::CH_SPACE : hrp_pkg::CH_TAB);
                n = $urandom_range(0, 12);
                for (i = 0; i < n; i++) add_byte(hrp_pkg::CH_ZERO + 8'($urandom_range(9)));
                if ($urandom_range(3) == 0) add_byte(noise_byte());
                add_line("");
            end
            1: begin
                add_mixed_case("Connection: ");
                add_mixed_case(conn_values[$urandom_range(5)]);
                add_line("");
            end
            default: begin
                add_mixed_case(other_headers[$urandom_range(5)]);
                add_line("");
            end
        endcase
    endtask

    // Mostly well-formed heads with random content; the rest is noise or broken heads.
    task automatic build_random_request();
        int unsigned roll;
        int unsigned n;
        int unsigned i;
        roll = $urandom_range(99);
        if (roll < 12) begin
            n = $urandom_range(3, 30);
            for (i = 0; i < n; i++) add_byte(noise_byte());
            if ($urandom_range(1) != 0) begin
                add_line("");
                add_line("");
            end
            return;
        end
        if (roll < 20) begin
            if ($urandom_range(1) != 0) add_mixed_case("GET ");
            else add_mixed_case("POST ");
        end else begin
            if ($urandom_range(1) != 0) add_text("GET ");
            else add_text("POST ");
        end
        n = ($urandom_range(9) == 0) ? $urandom_range(120, 135) : $urandom_range(0, 6);
        for (i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0) add_byte(8'($urandom_range(255)));
            else add_byte(8'($urandom_range(8'h21, 8'h7E)));
        end
        if ($urandom_range(3) == 0) begin
            add_byte(hrp_pkg::CH_QMARK);
            add_text("k=v");
        end
        if ($urandom_range(9) != 0) add_byte(hrp_pkg::CH_SPACE);
        add_line("HTTP/1.1");
        n = $urandom_range(0, 3);
        for (i = 0; i < n; i++) add_header();
        if ($urandom_range(99) < 85) add_line("");
    endtask

    // Receiver: random stalls plus one long hold-off on request.
    initial begin
        bit hold_taken;
        int unsigned hold_left;
        hold_taken = 0;
        hold_left = 0;
        res.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                res.ready <= 1'b0;
            end else res.ready <= !(idle_on && $urandom_range(99) < 17);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res.valid && res.ready) begin
                seen_word.kind = res.kind;
                seen_word.path_char = res.path_char;
                seen_word.status = res.status;
                seen_word.method = res.method;
                seen_word.head_len = res.head_len;
                seen_word.path_len = res.path_len;
                seen_word.body_len = res.body_len;
                seen_word.conn_close = res.conn_close;
                board.check_result(seen_word);
            end
            if ((req.valid && req.ready) || (res.valid && res.ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Timeout: no word moved for %0d cycles.", QUIET_LIMIT);
                $display("http_request_head_parser_core verification failed");
                $finish;
            end
        end
    end

    initial begin
        int k;
        int unsigned base_bytes;
        int unsigned req_n;
        board = new();
        i_rst_n = 1'b0;
        req.valid = 1'b0;
        req.head_byte = 8'h00;
        req.start_flag = 1'b0;
        idle_on = 1;
        hold_req = 0;
        sent_bytes = 0;
        quiet_cycles = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The first head relies on reset alone, without a start flag.
        add_line("GET / HTTP/1.1");
        add_line("");
        send_request(0);
        add_line("POST /a?x=1 HTTP/1.1");
        add_line("Content-Length: 42");
        add_line("");
        send_request(1);
        add_line("GET /p HTTP/1.1");
        add_line("connection: keep-alive, cClOsE");
        add_line("");
        send_request(1);
        add_line("POST /u HTTP/1.1");
        add_line("CONTENT-LENGTH:\t 4294967295");
        add_line("");
        send_request(1);
        add_line("POST /w HTTP/1.1");
        add_line("Content-Length: 7");
        add_line("content-length:99999999999");
        add_line("Connectio: close");
        add_line("");
        send_request(1);
        add_line("GET /v HTTP/1.1");
        add_line("Content-Length: 12x5");
        add_line("Content-Length: abc");
        add_line("Content-Lengthy: 5");
        add_line("Conn: close");
        add_line("");
        send_request(1);
        add_line("PUT / HTTP/1.1");
        add_line("");
        send_request(1);
        add_line("GEX / HTTP/1.1");
        add_line("");
        send_request(1);
        add_line("get / HTTP/1.1");
        add_line("");
        send_request(1);
        add_line("POSX / HTTP/1.1");
        add_line("");
        send_request(1);
        // A path without a closing space takes in the CR and LF bytes too.
        add_text("GET /abc");
        add_line("");
        add_line("");
        send_request(1);
        add_line("GET  HTTP/1.1");
        add_line("");
        send_request(1);
        add_line("GET ?q HTTP/1.1");
        add_line("");
        send_request(1);
        add_text("GET /");
        add_fill("a", PATH_LIMIT - 2);
        add_line(" HTTP/1.1");
        add_line("");
        send_request(1);
        add_text("POST /");
        add_fill("b", PATH_LIMIT - 1);
        add_line("?x HTTP/1.1");
        add_line("");
        send_request(1);
        add_text("GET /");
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(8'h7F);
        add_byte(8'h80);
        add_line(" HTTP/1.1");
        add_line("");
        send_request(1);
        // Bytes after a summary are ignored until the next start flag.
        add_line("GET /late HTTP/1.1");
        add_line("");
        send_request(0);
        add_text("POST /abc");
        send_request(1);
        add_line("POST /new HTTP/1.1");
        add_line("Connection: close");
        add_line("");
        send_request(1);
        add_line("");
        add_line("");
        send_request(1);
        add_text("GET /");
        add_fill("z", HEAD_LIMIT - 5);
        send_request(1);
        add_line("GET /x HTTP/1.1");
        add_text("X:");
        add_fill("z", HEAD_LIMIT - 23);
        add_line("");
        add_line("");
        send_request(1);

        base_bytes = sent_bytes;
        req_n = 0;
        idle_on = 0;
        while (sent_bytes - base_bytes < RANDOM_BYTES) begin
            if (req_n == 4) idle_on = 1;
            if (req_n == 7) hold_req = 1;
            build_random_request();
            send_request($urandom_range(19) != 0);
            req_n++;
        end
        req.valid <= 1'b0;

        for (k = 0; k < 400 && board.expected_words.size() != 0; k++) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (board.expected_words.size() != 0)
            board.report_mismatch($sformatf("%0d expected results never arrived",
                                            board.expected_words.size()));
        if (board.mismatches == 0) $display("http_request_head_parser_core verification clean");
        else $display("http_request_head_parser_core verification failed");
        $finish;
    end

endmodule

`default_nettype wire
